>>> rtl/length_prefixed_frame_extractor_macros.svh
// assertion macros for the length prefixed frame extractor
// bodies refer to the aclk and aresetn of the module that includes this file
`ifndef LENGTH_PREFIXED_FRAME_EXTRACTOR_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF

// check held off while reset is asserted
`define LPFE_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("lpfe assertion failed");

// check that also covers cycles in reset
`define LPFE_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("lpfe reset assertion failed");

`else

`define LPFE_ASSERT(label, prop)
`define LPFE_ASSERT_RST(label, prop)

`endif

`endif

>>> rtl/lpfe_pkg.sv
// shared types and constants for the length prefixed frame extractor
// no dependencies
package lpfe_pkg;

    // frame header layout
    localparam int LEN_W   = 20;
    localparam int FLAGS_W = 11;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 3;
    localparam int HDR_BYTES = 4;

    // smallest legal frame length, the header itself
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(HDR_BYTES);

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DATA     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NEG_LEN  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_OVER_BUF = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVER_CAP = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SHORT    = 3'd4;

    // output queue sizing
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QLVL_W = 4;
    localparam int PUSH_W = 3;

    // one result word
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [FLAGS_W-1:0] frame_flags;
        logic               frame_last;
        logic [STAT_W-1:0]  status;
    } result_t;

    // burst of up to four result words from one input word, word 0 goes first
    typedef struct packed {
        logic [PUSH_W-1:0]       count;
        result_t [HDR_BYTES-1:0] word;
    } push_t;

    // queue status toward the input side
    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              room;
    } q_stat_t;

endpackage

>>> rtl/lpfe_parser.sv
// header collection, header checks and payload pass-through
// depends on lpfe_pkg
module lpfe_parser #(
    parameter int BUFFER_LIMIT = 65536
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_accept,
    input  logic [lpfe_pkg::BYTE_W-1:0] in_byte,
    input  logic [lpfe_pkg::LEN_W-1:0]  max_len,
    output lpfe_pkg::push_t             push
);

    localparam int LIMIT_W = lpfe_pkg::LEN_W + 1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_ERROR   = 3'b100
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [31:0]                   shift_reg, shift_next;
    logic [1:0]                    cnt_reg, cnt_next;
    logic [lpfe_pkg::LEN_W-1:0]    left_reg, left_next;
    logic [lpfe_pkg::FLAGS_W-1:0]  flags_reg, flags_next;

    logic [31:0]                   hdr;
    logic [lpfe_pkg::LEN_W-1:0]    hdr_len;
    logic [lpfe_pkg::FLAGS_W-1:0]  hdr_flags;
    logic [lpfe_pkg::STAT_W-1:0]   hdr_status;
    logic [lpfe_pkg::LEN_W-1:0]    left_dec;

    // header word as it stands after this byte
    assign hdr       = {shift_reg[23:0], in_byte};
    assign hdr_len   = hdr[lpfe_pkg::LEN_W-1:0];
    assign hdr_flags = hdr[30:20];
    assign left_dec  = left_reg - lpfe_pkg::LEN_W'(1);

    // header checks in priority order
    always_comb begin
        if (hdr[31]) begin
            hdr_status = lpfe_pkg::STAT_NEG_LEN;
        end else if ({1'b0, hdr_len} >= LIMIT_W'(BUFFER_LIMIT)) begin
            hdr_status = lpfe_pkg::STAT_OVER_BUF;
        end else if (hdr_len > max_len) begin
            hdr_status = lpfe_pkg::STAT_OVER_CAP;
        end else if (hdr_len < lpfe_pkg::MIN_LEN) begin
            hdr_status = lpfe_pkg::STAT_SHORT;
        end else begin
            hdr_status = lpfe_pkg::STAT_DATA;
        end
    end

    // next state and result burst
    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        flags_next = flags_reg;
        push       = '0;
        if (in_accept) begin
            unique case (phase_reg)
                PH_PAYLOAD: begin
                    left_next = left_dec;
                    push.count = lpfe_pkg::PUSH_W'(1);
                    push.word[0].out_byte    = in_byte;
                    push.word[0].frame_flags = flags_reg;
                    push.word[0].frame_last  = (left_dec == '0);
                    push.word[0].status      = lpfe_pkg::STAT_DATA;
                    if (left_dec == '0) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    shift_next = hdr;
                    cnt_next   = cnt_reg + 2'd1;
                    // fourth byte completes the header
                    if (cnt_reg == 2'd3) begin
                        if (hdr == '0) begin
                            // empty header, skip silently
                        end else if (hdr_status != lpfe_pkg::STAT_DATA) begin
                            phase_next = PH_ERROR;
                            push.count = lpfe_pkg::PUSH_W'(1);
                            push.word[0].out_byte    = '0;
                            push.word[0].frame_flags = hdr_flags;
                            push.word[0].frame_last  = 1'b0;
                            push.word[0].status      = hdr_status;
                        end else begin
                            flags_next = hdr_flags;
                            left_next  = hdr_len - lpfe_pkg::MIN_LEN;
                            push.count = lpfe_pkg::PUSH_W'(lpfe_pkg::HDR_BYTES);
                            for (int k = 0; k < lpfe_pkg::HDR_BYTES; k++) begin
                                push.word[k].out_byte    = hdr[31 - 8*k -: 8];
                                push.word[k].frame_flags = hdr_flags;
                                push.word[k].frame_last  = 1'b0;
                                push.word[k].status      = lpfe_pkg::STAT_DATA;
                            end
                            push.word[lpfe_pkg::HDR_BYTES-1].frame_last =
                                (hdr_len == lpfe_pkg::MIN_LEN);
                            if (hdr_len != lpfe_pkg::MIN_LEN) begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_ERROR: begin
                    // drop everything until reset
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            shift_reg <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            flags_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            flags_reg <= flags_next;
        end
    end

endmodule

>>> rtl/lpfe_out_queue.sv
// output queue, takes bursts of up to four words and hands them out one a cycle while pop is high
// depends on lpfe_pkg
module lpfe_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpfe_pkg::push_t     push,
    input  logic                pop,
    output logic                out_valid,
    output lpfe_pkg::result_t   out_word,
    output lpfe_pkg::q_stat_t   stat
);

    lpfe_pkg::result_t                mem [lpfe_pkg::QDEPTH];
    logic [lpfe_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lpfe_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lpfe_pkg::QLVL_W-1:0]      level_reg, level_next;
    logic [lpfe_pkg::QPTR_W-1:0]      wr_off [lpfe_pkg::QDEPTH];
    logic [lpfe_pkg::QDEPTH-1:0]      wr_en;

    // per entry offset into the incoming burst
    always_comb begin
        for (int i = 0; i < lpfe_pkg::QDEPTH; i++) begin
            wr_off[i] = lpfe_pkg::QPTR_W'(i) - wr_ptr_reg;
            wr_en[i]  = ({1'b0, wr_off[i]} < {1'b0, push.count});
        end
    end

    // pointer and fill level update
    always_comb begin
        rd_ptr_next = rd_ptr_reg + lpfe_pkg::QPTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + lpfe_pkg::QPTR_W'(push.count);
        level_next  = level_reg + lpfe_pkg::QLVL_W'(push.count)
                      - lpfe_pkg::QLVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            level_reg  <= level_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < lpfe_pkg::QDEPTH; i++) begin
            if (wr_en[i]) begin
                mem[i] <= push.word[wr_off[i][1:0]];
            end
        end
    end

    // head of queue
    assign out_valid  = (level_reg != '0);
    assign out_word   = mem[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.room  = (level_reg <=
                         lpfe_pkg::QLVL_W'(lpfe_pkg::QDEPTH - lpfe_pkg::HDR_BYTES));

endmodule

>>> rtl/length_prefixed_frame_extractor.sv
// Length prefixed frame extractor: takes one received byte per cycle while
// s_tready is high and delivers one frame word per cycle while m_tready is
// high. A byte is accepted every cycle while the eight-word output queue has
// at least four free slots; the fourth byte of a header pushes all four header
// words at once, and the first three bytes of a header push nothing, so a
// steady stream with m_tready high runs at one byte per cycle. A header with
// bit 31 set, a length at or above BUFFER_LIMIT, above max_frame_len or below
// four yields a single error word (out_byte zero, status nonzero) and then all
// further bytes are dropped until reset. An all-zero header is skipped.
// cfg_wdata sets max_frame_len, reset value 65535.
`include "length_prefixed_frame_extractor_macros.svh"
module length_prefixed_frame_extractor #(
    parameter int BUFFER_LIMIT = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write of max_frame_len
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    // received stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // frame stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // frame_last
    output logic [13:0] m_tuser     // [10:0] frame_flags, [13:11] status
);

    logic [lpfe_pkg::LEN_W-1:0] max_len_reg;
    logic                       in_accept;
    logic                       pop;
    lpfe_pkg::push_t            push;
    lpfe_pkg::result_t          head;
    lpfe_pkg::q_stat_t          q_stat;

    // consumer capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= lpfe_pkg::LEN_W'(65535);
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    // handshakes
    assign s_tready  = q_stat.room;
    assign in_accept = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    lpfe_parser #(
        .BUFFER_LIMIT(BUFFER_LIMIT)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .max_len   (max_len_reg),
        .push      (push)
    );

    lpfe_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_word  (head),
        .stat      (q_stat)
    );

    // output word fields
    assign m_tdata = head.out_byte;
    assign m_tlast = head.frame_last;
    assign m_tuser = {head.status, head.frame_flags};

    // queue never holds more than its depth
    `LPFE_ASSERT(a_level_bound, q_stat.level <= lpfe_pkg::QLVL_W'(lpfe_pkg::QDEPTH))
    // a burst only lands when four slots were free
    `LPFE_ASSERT(a_push_room, (push.count != '0) |-> (q_stat.level <= 4'd4))
    // one byte yields no word, one word or a full header
    `LPFE_ASSERT(a_push_size, push.count == 3'd0 || push.count == 3'd1 || push.count == 3'd4)
    // nothing offered right after reset
    `LPFE_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid)

endmodule

>>> test/length_prefixed_frame_extractor_tb.sv
// self-checking testbench for length_prefixed_frame_extractor
// depends on lpfe_pkg and the rtl top level; carries its own deframing predictor
module length_prefixed_frame_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_LIMIT   = 65536;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef enum logic [2:0] {
        HUNT_HDR   = 3'b001,
        IN_PAYLOAD = 3'b010,
        DROPPING   = 3'b100
    } deframe_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [13:0] m_tuser;

    // stimulus and expectations
    logic [7:0]        rx_bytes[$];
    lpfe_pkg::result_t expected_words[$];
    int                mismatches = 0;
    int                stall_cycles = 0;
    bit                steady = 1'b0;

    // predictor state
    deframe_phase_t                 ph_q = HUNT_HDR;
    logic [31:0]                    hdr_shift = '0;
    logic [1:0]                     hdr_cnt = '0;
    logic [lpfe_pkg::LEN_W-1:0]     left_q = '0;
    logic [lpfe_pkg::FLAGS_W-1:0]   flags_q = '0;
    logic [lpfe_pkg::LEN_W-1:0]     cap_q = 20'd65535;

    always #4 aclk = ~aclk;

    length_prefixed_frame_extractor #(
        .BUFFER_LIMIT(BUF_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // predict the frame words that one accepted byte releases
    task automatic deframe_byte(input logic [7:0] b);
        lpfe_pkg::result_t            w;
        logic [31:0]                  h;
        logic [lpfe_pkg::LEN_W-1:0]   len;
        logic [lpfe_pkg::FLAGS_W-1:0] fl;
        logic [lpfe_pkg::STAT_W-1:0]  st;
        case (ph_q)
            DROPPING: begin
            end
            IN_PAYLOAD: begin
                left_q = left_q - 1'b1;
                w.out_byte    = b;
                w.frame_flags = flags_q;
                w.frame_last  = (left_q == '0);
                w.status      = lpfe_pkg::STAT_DATA;
                expected_words.push_back(w);
                if (left_q == '0)
                    ph_q = HUNT_HDR;
            end
            default: begin
                hdr_shift = {hdr_shift[23:0], b};
                if (hdr_cnt < 2'd3) begin
                    hdr_cnt = hdr_cnt + 1'b1;
                end else begin
                    hdr_cnt = '0;
                    h   = hdr_shift;
                    len = h[lpfe_pkg::LEN_W-1:0];
                    fl  = h[30:20];
                    // all-zero header is skipped silently
                    if (h != '0) begin
                        if (h[31])
                            st = lpfe_pkg::STAT_NEG_LEN;
                        else if (int'(len) >= BUF_LIMIT)
                            st = lpfe_pkg::STAT_OVER_BUF;
                        else if (len > cap_q)
                            st = lpfe_pkg::STAT_OVER_CAP;
                        else if (len < lpfe_pkg::MIN_LEN)
                            st = lpfe_pkg::STAT_SHORT;
                        else
                            st = lpfe_pkg::STAT_DATA;
                        if (st != lpfe_pkg::STAT_DATA) begin
                            w.out_byte    = '0;
                            w.frame_flags = fl;
                            w.frame_last  = 1'b0;
                            w.status      = st;
                            expected_words.push_back(w);
                            ph_q = DROPPING;
                        end else begin
                            flags_q = fl;
                            left_q  = len - lpfe_pkg::MIN_LEN;
                            for (int k = 0; k < lpfe_pkg::HDR_BYTES; k++) begin
                                w.out_byte    = h[8*(3-k) +: 8];
                                w.frame_flags = fl;
                                w.frame_last  = (k == 3) && (left_q == '0);
                                w.status      = lpfe_pkg::STAT_DATA;
                                expected_words.push_back(w);
                            end
                            ph_q = (left_q != '0) ? IN_PAYLOAD : HUNT_HDR;
                        end
                    end
                end
            end
        endcase
    endtask

    // input side: feed bytes from rx_bytes, predict on every accepted byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (rx_bytes.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
                    s_tdata  <= rx_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random back-pressure and field compare
    always @(posedge aclk) begin
        lpfe_pkg::result_t w;
        m_tready <= steady || ($urandom_range(99) >= 28);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: data %0h user %0h last %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                w = expected_words.pop_front();
                if (m_tdata !== w.out_byte) begin
                    $error("out_byte expected %0h actual %0h", w.out_byte, m_tdata);
                    mismatches++;
                end
                if (m_tuser[10:0] !== w.frame_flags) begin
                    $error("frame_flags expected %0h actual %0h",
                           w.frame_flags, m_tuser[10:0]);
                    mismatches++;
                end
                if (m_tlast !== w.frame_last) begin
                    $error("frame_last expected %0b actual %0b", w.frame_last, m_tlast);
                    mismatches++;
                end
                if (m_tuser[13:11] !== w.status) begin
                    $error("status expected %0d actual %0d", w.status, m_tuser[13:11]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[length_prefixed_frame_extractor] ERROR");
            $finish;
        end
    end

    // payload byte with extra weight on the all-zero and all-one values
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic push_header(input logic [31:0] h);
        for (int k = 3; k >= 0; k--)
            rx_bytes.push_back(h[8*k +: 8]);
    endtask

    task automatic add_frame(input int len, input logic [10:0] fl);
        push_header({1'b0, fl, 20'(len)});
        for (int i = 4; i < len; i++)
            rx_bytes.push_back(pick_byte());
    endtask

    // mostly short well-formed frames, some zero headers in between
    task automatic random_run(input int n_bytes, input int cap);
        int top;
        int len;
        int start;
        top   = (cap < 24) ? cap : 24;
        start = rx_bytes.size();
        while (rx_bytes.size() - start < n_bytes) begin
            if ($urandom_range(99) < 6) begin
                push_header('0);
            end else begin
                len = $urandom_range(top, 4);
                if (cap <= 64 && $urandom_range(9) == 0)
                    len = cap;
                add_frame(len, 11'($urandom));
            end
        end
    endtask

    // wait until the block has gone quiet between phases
    task automatic wait_drained();
        while (rx_bytes.size() != 0 || expected_words.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cap(input logic [19:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cap_q = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [lpfe_pkg::STAT_W-1:0] kind;
        int                          final_cap;
        logic [31:0]                 bad_hdr;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: header-only frame, max flags, zero header, extreme payload bytes
        add_frame(4, 11'h000);
        add_frame(5, 11'h7FF);
        push_header('0);
        push_header({1'b0, 11'h5A5, 20'd6});
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(8'hFF);
        wait_drained();

        // random traffic under the reset capacity
        random_run(70, 65535);
        wait_drained();

        // capacity at the header size: only header-only frames pass
        write_cap(20'd4);
        random_run(40, 4);
        wait_drained();

        // widest capacity with both sides streaming without gaps
        write_cap(20'hFFFFF);
        steady = 1'b1;
        random_run(70, 1048575);
        wait_drained();
        steady = 1'b0;

        write_cap(20'h55555);
        random_run(70, 20'h55555);
        wait_drained();

        write_cap(20'hAAAAA);
        random_run(70, 20'hAAAAA);
        wait_drained();

        // small capacity, then one bad header; everything after it is dropped
        final_cap = $urandom_range(40, 8);
        write_cap(20'(final_cap));
        random_run(70, final_cap);
        kind = lpfe_pkg::STAT_W'($urandom_range(4, 1));
        case (kind)
            lpfe_pkg::STAT_NEG_LEN: bad_hdr = {1'b1, 31'($urandom)};
            lpfe_pkg::STAT_OVER_BUF:
                bad_hdr = {1'b0, 11'($urandom), 20'($urandom_range(1048575, BUF_LIMIT))};
            lpfe_pkg::STAT_OVER_CAP:
                bad_hdr = {1'b0, 11'($urandom), 20'($urandom_range(65535, final_cap + 1))};
            default: begin
                if ($urandom_range(1))
                    bad_hdr = {1'b0, 11'($urandom), 20'($urandom_range(3, 1))};
                else
                    bad_hdr = {1'b0, 11'($urandom_range(2047, 1)), 20'd0};
            end
        endcase
        push_header(bad_hdr);
        for (int i = 0; i < 12; i++)
            rx_bytes.push_back(pick_byte());
        add_frame(8, 11'($urandom));

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("[length_prefixed_frame_extractor] OK");
        else
            $display("[length_prefixed_frame_extractor] ERROR");
        $finish;
    end

endmodule
